// ===== design/smb_pkg.sv =====
// shared types, constants and helpers for the masked sprite blitter
package smb_pkg;

   localparam int NUM_SHAPES  = 16;
   localparam int SHAPE_BYTES = 256;
   localparam int VRAM_BYTES  = 16384;
   localparam int NUM_LINES   = 256;

   localparam int SHAPE_AW = $clog2(NUM_SHAPES * SHAPE_BYTES);
   localparam int SOFF_W   = $clog2(SHAPE_BYTES);
   localparam int SSEL_W   = $clog2(NUM_SHAPES);
   localparam int VRAM_AW  = $clog2(VRAM_BYTES);
   localparam int LINE_W   = $clog2(NUM_LINES);

   localparam logic [15:0] WRITE_LIMIT = 16'h1fff;

   typedef enum logic [2:0] {
      REQ_HEADER = 3'd0,
      REQ_SHAPE  = 3'd1,
      REQ_LINE   = 3'd2,
      REQ_DRAW   = 3'd3,
      REQ_VWRITE = 3'd4,
      REQ_VREAD  = 3'd5
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_BLIT_WIDTH  = 1'b0,
      CSR_BLIT_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LINE,
      ST_LINE_WAIT,
      ST_PRE_RD,
      ST_PRE_WAIT,
      ST_BYTE_RD,
      ST_BYTE_WAIT,
      ST_BYTE_WR,
      ST_TAIL_RD,
      ST_TAIL_WAIT,
      ST_TAIL_WR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  shape_sel;
      logic [7:0]  byte_index;
      logic [7:0]  byte_value;
      logic [7:0]  shape_width;
      logic [7:0]  shape_height;
      logic [1:0]  bits_per_pixel;
      logic [7:0]  line_sel;
      logic [13:0] vram_addr;
      logic [15:0] xpos;
      logic [15:0] ypos;
      logic        mask_mode;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       write_rejected;
   } rsp_payload_type;

   // shared merge unit control
   typedef struct packed {
      logic       masked;
      logic       tail;
      logic [2:0] pixx;
      logic [7:0] carry;
      logic [7:0] mask;
      logic [7:0] shape;
      logic [7:0] screen;
   } merge_ctl_type;

   function automatic logic [7:0] keep_mask(input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (b[2*i +: 2] == 2'b00) begin
            r[2*i +: 2] = 2'b11;
         end
      end
      return r;
   endfunction

endpackage

// ===== design/smb_merge.sv =====
// pixel shift and merge unit shared by every byte of a draw
module smb_merge (
   input  smb_pkg::merge_ctl_type ctl,
   output logic [7:0]             merged,
   output logic [7:0]             next_carry,
   output logic [7:0]             next_mask
);
   logic [7:0]  km;
   logic [15:0] sh_shape;
   logic [15:0] sh_keep;
   logic [7:0]  cur;
   logic [7:0]  cur_m;
   logic [7:0]  back;

   always_comb begin
      km         = smb_pkg::keep_mask(ctl.shape);
      sh_shape   = {ctl.shape, 8'h00} >> ctl.pixx;
      sh_keep    = {km, 8'h00} >> ctl.pixx;
      back       = 8'hff >> ctl.pixx;
      next_carry = sh_shape[7:0];
      next_mask  = sh_keep[7:0];
      if (ctl.tail) begin
         cur   = ctl.carry;
         cur_m = ctl.mask | back;
      end else begin
         cur   = ctl.carry | sh_shape[15:8];
         cur_m = ctl.mask | sh_keep[15:8];
      end
      if (ctl.masked) begin
         merged = (ctl.screen & cur_m) | cur;
      end else begin
         merged = ctl.screen ^ cur;
      end
   end
endmodule

// ===== design/smb_seq.sv =====
// draw sequencer with shape, line and video memories
module smb_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  smb_pkg::req_payload_type req,
   input  logic [7:0]               blit_width,
   input  logic [7:0]               blit_height,
   output logic                     done,
   output smb_pkg::rsp_payload_type result,
   output smb_pkg::merge_ctl_type   mctl,
   input  logic [7:0]               merged,
   input  logic [7:0]               next_carry,
   input  logic [7:0]               next_mask
);
   logic [7:0]  vram [smb_pkg::VRAM_BYTES];
   logic [7:0]  shape_mem [smb_pkg::NUM_SHAPES * smb_pkg::SHAPE_BYTES];
   logic [12:0] line_mem [smb_pkg::NUM_LINES];

   logic [7:0] wtab_ff [smb_pkg::NUM_SHAPES];
   logic [7:0] htab_ff [smb_pkg::NUM_SHAPES];
   logic [1:0] dtab_ff [smb_pkg::NUM_SHAPES];

   smb_pkg::state_type state_ff, state_in;
   smb_pkg::req_payload_type req_ff;

   logic [7:0]  vrd_ff, srd_ff;
   logic [12:0] lrd_ff;
   logic [15:0] vaddr;
   logic        vwe;
   logic [15:0] saddr_full;

   logic [7:0]  w_ff, xlen_ff, ylen_ff, xs_ff, ys_ff, xv_ff, vs_ff, x_ff, y_ff;
   logic [7:0]  w_in, xlen_in, ylen_in, xs_in, ys_in, xv_in, vs_in, x_in, y_in;
   logic [2:0]  pixx_ff, pixx_in;
   logic        masked_ff, masked_in, tail_ff, tail_in;
   logic [7:0]  c_ff, c_in, m_ff, m_in, front;
   logic [15:0] base_ff, base_in, vpos_ff, vpos_in;
   logic        rej_ff, rej_in;
   logic [7:0]  rd_ff, rd_in;
   logic [7:0]  p_ff, p_in;

   // setup arithmetic
   logic        two;
   logic [13:0] bytex;
   logic [16:0] ypos_s, h17, bh17;
   logic [14:0] xw;
   logic signed [17:0] vst, xvst, ymin, xmin, yl, xl;
   logic [smb_pkg::SSEL_W-1:0] sidx;

   // tail uses the merge unit with carry only
   logic merge_tail;

   assign sidx = req_ff.shape_sel[smb_pkg::SSEL_W-1:0];
   assign two  = (dtab_ff[sidx] == 2'd2);
   assign merge_tail = (state_ff == smb_pkg::ST_TAIL_WR);

   always_comb begin
      bytex = two ? req_ff.xpos[15:2] : {1'b0, req_ff.xpos[15:3]};
      vst   = $signed({2'b00, req_ff.ypos}) - $signed({10'd0, htab_ff[sidx]});
      if (vst < 0) vst = '0;
      ymin  = (req_ff.ypos < {8'd0, blit_height}) ? $signed({2'b00, req_ff.ypos})
                                                  : $signed({10'd0, blit_height});
      yl    = ymin - vst;
      if (yl < 0) yl = '0;
      xvst  = $signed({4'd0, bytex}) - $signed({10'd0, wtab_ff[sidx]});
      if (xvst < 0) xvst = '0;
      xmin  = (bytex < {6'd0, blit_width}) ? $signed({4'd0, bytex})
                                           : $signed({10'd0, blit_width});
      xl    = xmin - xvst;
      if (xl < 0) xl = '0;
      ypos_s = {1'b0, req_ff.ypos};
      h17    = {9'd0, htab_ff[sidx]};
      bh17   = {9'd0, blit_height};
      xw     = {1'b0, bytex};
   end

   assign front = 8'hff << (4'd8 - {1'b0, pixx_ff});
   assign saddr_full = base_ff + {8'd0, x_ff};

   always_comb begin
      mctl.masked = masked_ff;
      mctl.tail   = merge_tail;
      mctl.pixx   = pixx_ff;
      mctl.carry  = c_ff;
      mctl.mask   = m_ff;
      mctl.shape  = p_ff;
      mctl.screen = vrd_ff;
   end

   always_comb begin
      state_in  = state_ff;
      w_in = w_ff; xlen_in = xlen_ff; ylen_in = ylen_ff; xs_in = xs_ff;
      ys_in = ys_ff; xv_in = xv_ff; vs_in = vs_ff; x_in = x_ff; y_in = y_ff;
      pixx_in = pixx_ff; masked_in = masked_ff; tail_in = tail_ff;
      c_in = c_ff; m_in = m_ff; base_in = base_ff; vpos_in = vpos_ff;
      rej_in = rej_ff; rd_in = rd_ff; p_in = p_ff;
      vaddr = vpos_ff + {8'd0, x_ff};
      vwe = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         smb_pkg::ST_IDLE: begin
            if (start) begin
               rej_in = 1'b0;
               rd_in  = 8'h00;
               unique case (req.req_type)
                  smb_pkg::REQ_DRAW:   state_in = smb_pkg::ST_SETUP;
                  smb_pkg::REQ_VREAD:  state_in = smb_pkg::ST_READ_WAIT;
                  smb_pkg::REQ_VWRITE: begin
                     rej_in   = ({2'b00, req.vram_addr} >= smb_pkg::WRITE_LIMIT);
                     state_in = smb_pkg::ST_DONE;
                  end
                  default:             state_in = smb_pkg::ST_DONE;
               endcase
            end
         end
         smb_pkg::ST_READ_WAIT: begin
            rd_in    = vrd_ff;
            state_in = smb_pkg::ST_DONE;
         end
         smb_pkg::ST_SETUP: begin
            w_in      = wtab_ff[sidx];
            masked_in = req_ff.mask_mode & two;
            pixx_in   = two ? {req_ff.xpos[1:0], 1'b0} : req_ff.xpos[2:0];
            vs_in     = vst[7:0];
            ys_in     = 8'(vst - ($signed({2'b00, req_ff.ypos}) - $signed({10'd0, h17[7:0]})));
            ylen_in   = yl[7:0];
            xv_in     = xvst[7:0];
            xs_in     = 8'(xvst - ($signed({4'd0, bytex}) - $signed({10'd0, wtab_ff[sidx]})));
            xlen_in   = xl[7:0];
            y_in      = 8'd0;
            if ({2'b00, xw} >= {9'd0, blit_width} + {9'd0, wtab_ff[sidx]} ||
                ypos_s > bh17 + h17) begin
               state_in = smb_pkg::ST_DONE;
            end else begin
               state_in = smb_pkg::ST_LINE;
            end
            tail_in = (bytex < {6'd0, blit_width});
         end
         smb_pkg::ST_LINE: begin
            if (y_ff == ylen_ff) begin
               state_in = smb_pkg::ST_DONE;
            end else begin
               base_in  = 16'((ys_ff + y_ff) * w_ff) + {8'd0, xs_ff};
               state_in = smb_pkg::ST_LINE_WAIT;
            end
         end
         smb_pkg::ST_LINE_WAIT: begin
            vpos_in = {3'd0, lrd_ff} + {8'd0, xv_ff};
            x_in    = 8'd0;
            c_in    = 8'h00;
            m_in    = front;
            state_in = (xs_ff != 8'd0) ? smb_pkg::ST_PRE_RD : smb_pkg::ST_BYTE_RD;
         end
         smb_pkg::ST_PRE_RD: state_in = smb_pkg::ST_PRE_WAIT;
         smb_pkg::ST_PRE_WAIT: begin
            p_in     = srd_ff;
            state_in = smb_pkg::ST_BYTE_RD;
         end
         smb_pkg::ST_BYTE_RD: begin
            // carry and mask from the byte left of the clip edge
            if (xs_ff != 8'd0 && x_ff == 8'd0) begin
               c_in = next_carry;
               m_in = next_mask;
            end
            if (x_ff == xlen_ff) begin
               state_in = (pixx_ff != 3'd0 && tail_ff) ? smb_pkg::ST_TAIL_RD
                                                        : smb_pkg::ST_LINE;
               if (!(pixx_ff != 3'd0 && tail_ff)) y_in = y_ff + 8'd1;
            end else begin
               state_in = smb_pkg::ST_BYTE_WAIT;
            end
         end
         smb_pkg::ST_BYTE_WAIT: begin
            p_in     = srd_ff;
            state_in = smb_pkg::ST_BYTE_WR;
         end
         smb_pkg::ST_BYTE_WR: begin
            vwe = 1'b1;
            if (vaddr >= smb_pkg::WRITE_LIMIT) rej_in = 1'b1;
            c_in = next_carry;
            m_in = next_mask;
            x_in = x_ff + 8'd1;
            state_in = smb_pkg::ST_BYTE_RD;
         end
         smb_pkg::ST_TAIL_RD: state_in = smb_pkg::ST_TAIL_WAIT;
         smb_pkg::ST_TAIL_WAIT: state_in = smb_pkg::ST_TAIL_WR;
         smb_pkg::ST_TAIL_WR: begin
            vwe = 1'b1;
            if (vaddr >= smb_pkg::WRITE_LIMIT) rej_in = 1'b1;
            y_in = y_ff + 8'd1;
            state_in = smb_pkg::ST_LINE;
         end
         smb_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = smb_pkg::ST_IDLE;
         end
         default: state_in = smb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smb_pkg::ST_IDLE;
         for (int i = 0; i < smb_pkg::NUM_SHAPES; i++) begin
            wtab_ff[i] <= 8'd0;
            htab_ff[i] <= 8'd0;
            dtab_ff[i] <= 2'd0;
         end
      end else begin
         state_ff <= state_in;
         if (start && state_ff == smb_pkg::ST_IDLE &&
             req.req_type == smb_pkg::REQ_HEADER) begin
            wtab_ff[req.shape_sel[smb_pkg::SSEL_W-1:0]] <= req.shape_width;
            htab_ff[req.shape_sel[smb_pkg::SSEL_W-1:0]] <= req.shape_height;
            dtab_ff[req.shape_sel[smb_pkg::SSEL_W-1:0]] <= req.bits_per_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == smb_pkg::ST_IDLE) req_ff <= req;
      w_ff <= w_in; xlen_ff <= xlen_in; ylen_ff <= ylen_in; xs_ff <= xs_in;
      ys_ff <= ys_in; xv_ff <= xv_in; vs_ff <= vs_in; x_ff <= x_in; y_ff <= y_in;
      pixx_ff <= pixx_in; masked_ff <= masked_in;
      tail_ff <= tail_in;
      c_ff <= c_in; m_ff <= m_in; base_ff <= base_in; vpos_ff <= vpos_in;
      rej_ff <= rej_in; rd_ff <= rd_in; p_ff <= p_in;
   end

   // memories
   logic [smb_pkg::VRAM_AW-1:0] vrd_addr;
   assign vrd_addr = (state_ff == smb_pkg::ST_IDLE) ? req.vram_addr[smb_pkg::VRAM_AW-1:0]
                                                   : vaddr[smb_pkg::VRAM_AW-1:0];

   always_ff @(posedge clock) begin
      vrd_ff <= vram[vrd_addr];
      if (vwe && vaddr < smb_pkg::WRITE_LIMIT) begin
         vram[vaddr[smb_pkg::VRAM_AW-1:0]] <= merged;
      end else if (start && state_ff == smb_pkg::ST_IDLE &&
                   req.req_type == smb_pkg::REQ_VWRITE &&
                   {2'b00, req.vram_addr} < smb_pkg::WRITE_LIMIT) begin
         vram[req.vram_addr[smb_pkg::VRAM_AW-1:0]] <= req.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      srd_ff <= shape_mem[{sidx, (state_ff == smb_pkg::ST_PRE_RD) ?
                           8'(base_ff - 16'd1) : saddr_full[smb_pkg::SOFF_W-1:0]}];
      if (start && state_ff == smb_pkg::ST_IDLE && req.req_type == smb_pkg::REQ_SHAPE) begin
         shape_mem[{req.shape_sel[smb_pkg::SSEL_W-1:0], req.byte_index}] <= req.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      lrd_ff <= line_mem[8'(vs_ff + y_ff)];
      if (start && state_ff == smb_pkg::ST_IDLE && req.req_type == smb_pkg::REQ_LINE) begin
         line_mem[req.line_sel[smb_pkg::LINE_W-1:0]] <= req.vram_addr[12:0];
      end
   end

   assign result.read_data      = rd_ff;
   assign result.write_rejected = rej_ff;

   unused_sink: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == smb_pkg::ST_DONE) else $error("done outside done state");
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      (done && req_ff.req_type != smb_pkg::REQ_VREAD) |-> rd_ff == 8'h00)
      else $error("read data on a non-read transfer");
   a_x_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smb_pkg::ST_BYTE_WR) |-> x_ff < xlen_ff)
      else $error("byte index past clipped length");
endmodule

// ===== design/sprite_masked_blitter_core.sv =====
// top level of the masked sprite blitter
//  channel  direction  handshake        payload
//  req      in         req_valid/stall  smb_pkg::req_payload_type
//  rsp      out        rsp_valid/stall  smb_pkg::rsp_payload_type
//  csr      in         csr_write        blit_width, blit_height
// a draw reads, merges and writes back each clipped byte of each line in turn
// through the read-modify-write path of the video memory
// req_stall stays high from acceptance until the result transfer completes
// the result register holds while rsp_stall is high
// reset is synchronous; shape header tables and control registers clear; stores and datapath registers do not
module sprite_masked_blitter_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  smb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output smb_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [0:0]               csr_index,
   input  logic [7:0]               csr_data
);
   logic [7:0] bw_ff, bh_ff;
   logic       busy_ff;
   logic       start, done;
   smb_pkg::rsp_payload_type res;
   smb_pkg::merge_ctl_type   mctl;
   logic [7:0] merged, ncarry, nmask;

   assign req_stall = busy_ff | rsp_valid;
   assign start     = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff     <= 8'd0;
         bh_ff     <= 8'd0;
         busy_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               smb_pkg::CSR_BLIT_WIDTH:  bw_ff <= csr_data;
               smb_pkg::CSR_BLIT_HEIGHT: bh_ff <= csr_data;
               default: ;
            endcase
         end
         if (start) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         if (done) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) rsp_payload <= res;
   end

   smb_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .req(req_payload),
      .blit_width(bw_ff), .blit_height(bh_ff), .done(done), .result(res),
      .mctl(mctl), .merged(merged), .next_carry(ncarry), .next_mask(nmask)
   );

   smb_merge u_merge (.ctl(mctl), .merged(merged), .next_carry(ncarry), .next_mask(nmask));
endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the masked sprite blitter core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int CLIP_MAX       = 32;
   localparam int LOW_SPAN       = 64;
   localparam int HIGH_BASE      = 'h1fe0;
   localparam int SHAPE_FILL     = 64;
   localparam int DRAW_SHAPES    = 4;
   localparam int PHASE_ITEMS    = 80;

   class blit_scoreboard;
      bit [7:0]  vram_img [smb_pkg::VRAM_BYTES];
      bit [7:0]  shape_img [smb_pkg::NUM_SHAPES*smb_pkg::SHAPE_BYTES];
      bit [7:0]  width_tab [smb_pkg::NUM_SHAPES];
      bit [7:0]  height_tab [smb_pkg::NUM_SHAPES];
      bit [1:0]  depth_tab [smb_pkg::NUM_SHAPES];
      bit [12:0] line_tab [smb_pkg::NUM_LINES];
      bit [7:0]  clip_w;
      bit [7:0]  clip_h;
      smb_pkg::rsp_payload_type expected_q[$];
      int errors;

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void set_reg(smb_pkg::csr_index_type idx, bit [7:0] v);
         if (idx == smb_pkg::CSR_BLIT_WIDTH) clip_w = v;
         else clip_h = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int unsigned transparent_bits(int unsigned b);
         int unsigned r;
         r = 0;
         for (int i = 0; i < 4; i++) begin
            if (((b >> (2*i)) & 3) == 0) r |= 3 << (2*i);
         end
         return r;
      endfunction

      function bit vram_store(int unsigned a, int unsigned d);
         if (a >= smb_pkg::WRITE_LIMIT) return 1'b1;
         vram_img[a % smb_pkg::VRAM_BYTES] = d[7:0];
         return 1'b0;
      endfunction

      function bit paint(int unsigned s, int unsigned xp, int unsigned yp, bit masked_req);
         int w, h, bytex, ypos, bw, bh, xvstart, xstart, xlen, vstart, ystart, ylen;
         bit two, masked, rej;
         int unsigned pixx, front, back, base, lp, vpos, c, m, p, a, b;
         w = width_tab[s];
         h = height_tab[s];
         two = depth_tab[s] == 2;
         masked = masked_req && two;
         pixx = two ? ((xp << 1) & 7) : (xp & 7);
         bytex = two ? int'(xp >> 2) : int'(xp >> 3);
         ypos = yp;
         bw = clip_w;
         bh = clip_h;
         front = (32'hff << (8 - pixx)) & 32'hff;
         back = 32'hff >> pixx;
         rej = 0;
         if (bytex >= bw + w || ypos > bh + h) return 1'b0;
         vstart = ypos - h;
         if (vstart < 0) vstart = 0;
         ystart = vstart - (ypos - h);
         ylen = (ypos < bh ? ypos : bh) - vstart;
         if (ylen < 0) ylen = 0;
         xvstart = bytex - w;
         if (xvstart < 0) xvstart = 0;
         xstart = xvstart - (bytex - w);
         xlen = (bytex < bw ? bytex : bw) - xvstart;
         if (xlen < 0) xlen = 0;
         for (int y = 0; y < ylen; y++) begin
            base = int'(ystart + y) * int'(w) + xstart;
            lp = line_tab[(vstart + y) % smb_pkg::NUM_LINES];
            vpos = lp + xvstart;
            c = 0;
            m = front;
            if (xstart > 0) begin
               p = shape_img[s*smb_pkg::SHAPE_BYTES + ((base - 1) % smb_pkg::SHAPE_BYTES)];
               c = (p << (8 - pixx)) & 32'hff;
               m = (transparent_bits(p) << (8 - pixx)) & 32'hff;
            end
            for (int x = 0; x < xlen; x++) begin
               p = shape_img[s*smb_pkg::SHAPE_BYTES + ((base + x) % smb_pkg::SHAPE_BYTES)];
               a = (vpos + x) & 32'hffff;
               b = vram_img[a % smb_pkg::VRAM_BYTES];
               if (masked) begin
                  b &= m | (transparent_bits(p) >> pixx);
                  b |= c | (p >> pixx);
               end else begin
                  b ^= c | (p >> pixx);
               end
               rej |= vram_store(a, b);
               c = (p << (8 - pixx)) & 32'hff;
               m = (transparent_bits(p) << (8 - pixx)) & 32'hff;
            end
            if (pixx != 0 && bytex < bw) begin
               a = (vpos + xlen) & 32'hffff;
               b = vram_img[a % smb_pkg::VRAM_BYTES];
               if (masked) begin
                  b &= m | back;
                  b |= c;
               end else begin
                  b ^= c;
               end
               rej |= vram_store(a, b);
            end
         end
         return rej;
      endfunction

      function void note(smb_pkg::req_payload_type r);
         smb_pkg::rsp_payload_type e;
         e = '0;
         case (r.req_type)
            smb_pkg::REQ_HEADER: begin
               width_tab[r.shape_sel] = r.shape_width;
               height_tab[r.shape_sel] = r.shape_height;
               depth_tab[r.shape_sel] = r.bits_per_pixel;
            end
            smb_pkg::REQ_SHAPE:
               shape_img[r.shape_sel*smb_pkg::SHAPE_BYTES + r.byte_index] = r.byte_value;
            smb_pkg::REQ_LINE: line_tab[r.line_sel] = r.vram_addr[12:0];
            smb_pkg::REQ_DRAW:
               e.write_rejected = paint(r.shape_sel, r.xpos, r.ypos, r.mask_mode);
            smb_pkg::REQ_VWRITE: e.write_rejected = vram_store(r.vram_addr, r.byte_value);
            smb_pkg::REQ_VREAD: e.read_data = vram_img[r.vram_addr % smb_pkg::VRAM_BYTES];
            default: ;
         endcase
         expected_q.push_back(e);
      endfunction

      function void check(smb_pkg::rsp_payload_type got);
         smb_pkg::rsp_payload_type e;
         if (expected_q.size() == 0) begin
            report("result transfer with nothing expected");
            return;
         end
         e = expected_q.pop_front();
         if (got.read_data !== e.read_data)
            report($sformatf("read_data %h, expected %h", got.read_data, e.read_data));
         if (got.write_rejected !== e.write_rejected)
            report($sformatf("write_rejected %b, expected %b",
                             got.write_rejected, e.write_rejected));
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_write;
   smb_pkg::req_payload_type req_payload;
   smb_pkg::rsp_payload_type rsp_payload;
   logic [0:0] csr_index;
   logic [7:0] csr_data;
   int send_idle, recv_stall, quiet_cycles;
   blit_scoreboard sb;

   sprite_masked_blitter_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= (recv_stall != 0) && ($urandom_range(0, 99) < recv_stall);
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_payload);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic smb_pkg::req_payload_type noise_payload(bit [2:0] kind);
      smb_pkg::req_payload_type p;
      p = {$urandom, $urandom, $urandom};
      p.req_type = kind;
      return p;
   endfunction

   // line starts in the low filled region or in the high filled region up to the write limit
   function automatic bit [13:0] safe_line_ptr();
      bit [13:0] v;
      if ($urandom_range(0, 1) == 0) v = 14'($urandom_range(0, CLIP_MAX - 1));
      else v = 14'($urandom_range(HIGH_BASE, 'h1fff));
      return v;
   endfunction

   function automatic bit [13:0] filled_addr();
      bit [13:0] v;
      if ($urandom_range(0, 1) == 0) v = 14'($urandom_range(0, LOW_SPAN - 1));
      else v = 14'($urandom_range(HIGH_BASE, 'h1ffe));
      return v;
   endfunction

   task automatic send(input smb_pkg::req_payload_type p);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      sb.note(p);
      if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input smb_pkg::csr_index_type idx, input bit [7:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   task automatic send_header(int s, int w, int h, int bpp);
      smb_pkg::req_payload_type p;
      p = noise_payload(smb_pkg::REQ_HEADER);
      p.shape_sel = 4'(s);
      p.shape_width = 8'(w);
      p.shape_height = 8'(h);
      p.bits_per_pixel = 2'(bpp);
      send(p);
   endtask

   task automatic send_draw(int s, int xp, int yp, bit msk);
      smb_pkg::req_payload_type p;
      p = noise_payload(smb_pkg::REQ_DRAW);
      p.shape_sel = 4'(s);
      p.xpos = 16'(xp);
      p.ypos = 16'(yp);
      p.mask_mode = msk;
      send(p);
   endtask

   task automatic send_vram(bit [2:0] kind, int a, int v);
      smb_pkg::req_payload_type p;
      p = noise_payload(kind);
      p.vram_addr = 14'(a);
      p.byte_value = 8'(v);
      send(p);
   endtask

   function automatic smb_pkg::req_payload_type random_item();
      smb_pkg::req_payload_type p;
      int pick, s, bytex, two;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         p = noise_payload(smb_pkg::REQ_DRAW);
         s = $urandom_range(0, DRAW_SHAPES - 1);
         p.shape_sel = 4'(s);
         two = sb.depth_tab[s] == 2;
         if ($urandom_range(0, 9) != 0) begin
            bytex = $urandom_range(0, sb.clip_w + sb.width_tab[s] + 1);
            p.xpos = two ? 16'(bytex*4 + $urandom_range(0, 3))
                         : 16'(bytex*8 + $urandom_range(0, 7));
            p.ypos = 16'($urandom_range(0, sb.clip_h + sb.height_tab[s] + 1));
         end
      end else if (pick < 55) begin
         p = noise_payload(smb_pkg::REQ_VWRITE);
      end else if (pick < 70) begin
         p = noise_payload(smb_pkg::REQ_VREAD);
         p.vram_addr = filled_addr();
      end else if (pick < 82) begin
         p = noise_payload(smb_pkg::REQ_HEADER);
         p.shape_width = 8'($urandom_range(0, 6));
         p.shape_height = 8'($urandom_range(0, 6));
         if ($urandom_range(0, 9) == 0) begin
            p.shape_width = 8'($urandom_range(7, SHAPE_FILL - 1));
            p.shape_height = 8'd1;
         end else if ($urandom_range(0, 9) == 0) begin
            p.shape_height = 8'($urandom_range(7, SHAPE_FILL - 1));
            p.shape_width = 8'd1;
         end
      end else if (pick < 92) begin
         p = noise_payload(smb_pkg::REQ_SHAPE);
      end else if (pick < 97) begin
         p = noise_payload(smb_pkg::REQ_LINE);
         p.vram_addr = safe_line_ptr();
      end else begin
         p = noise_payload(3'($urandom_range(6, 7)));
      end
      return p;
   endfunction

   initial begin
      smb_pkg::req_payload_type p;
      int bw_set [5] = '{32, 20, 0, 8, 32};
      int bh_set [5] = '{32, 30, 0, 32, 1};
      int sidle [5] = '{0, 73, 0, 33, 0};
      int rstall [5] = '{0, 0, 73, 33, 0};
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 0;
      recv_stall = 0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every entry a draw or a read can reach
      for (int i = 0; i < CLIP_MAX; i++) begin
         p = noise_payload(smb_pkg::REQ_LINE);
         p.line_sel = 8'(i);
         p.vram_addr = safe_line_ptr();
         send(p);
      end
      for (int i = 0; i < LOW_SPAN; i++) send_vram(smb_pkg::REQ_VWRITE, i, $urandom);
      for (int i = HIGH_BASE; i < 'h1fff; i++) send_vram(smb_pkg::REQ_VWRITE, i, $urandom);
      for (int s = 0; s < DRAW_SHAPES; s++) begin
         for (int i = 0; i < SHAPE_FILL; i++) begin
            p = noise_payload(smb_pkg::REQ_SHAPE);
            p.shape_sel = 4'(s);
            p.byte_index = 8'(i);
            send(p);
         end
      end
      drain();
      write_reg(smb_pkg::CSR_BLIT_WIDTH, 8'd16);
      write_reg(smb_pkg::CSR_BLIT_HEIGHT, 8'd16);

      send_header(0, 2, 2, 2);
      send_header(1, 3, 1, 1);
      send_header(2, 40, 1, 3);
      send_header(3, 0, 0, 0);
      send_draw(0, 8, 2, 1);
      send_draw(0, 9, 3, 1);
      send_draw(0, 13, 4, 0);
      send_draw(1, 3, 1, 1);
      send_draw(0, 1, 1, 1);
      send_draw(0, 71, 17, 1);
      send_draw(0, 65535, 65535, 1);
      send_draw(2, 128, 16, 0);
      send_draw(3, 40, 5, 0);
      send_vram(smb_pkg::REQ_VWRITE, 'h1fff, 8'hff);
      send_vram(smb_pkg::REQ_VWRITE, 'h3fff, 8'h00);
      send_vram(smb_pkg::REQ_VWRITE, 'h1ffe, 8'hff);
      send_vram(smb_pkg::REQ_VREAD, 'h1ffe, 0);
      send_vram(smb_pkg::REQ_VREAD, 0, 0);
      send(noise_payload(3'd6));
      send(noise_payload(3'd7));
      p = noise_payload(smb_pkg::REQ_SHAPE);
      p.shape_sel = 4'd15;
      p.byte_index = 8'd255;
      p.byte_value = 8'd255;
      send(p);
      p = noise_payload(smb_pkg::REQ_LINE);
      p.line_sel = 8'd255;
      p.vram_addr = 14'h3eff;
      send(p);
      send_draw(1, 5, 16, 0);

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         if (ph == 3) begin
            write_reg(smb_pkg::CSR_BLIT_WIDTH, 8'($urandom_range(1, CLIP_MAX)));
            write_reg(smb_pkg::CSR_BLIT_HEIGHT, 8'($urandom_range(1, CLIP_MAX)));
         end else begin
            write_reg(smb_pkg::CSR_BLIT_WIDTH, 8'(bw_set[ph]));
            write_reg(smb_pkg::CSR_BLIT_HEIGHT, 8'(bh_set[ph]));
         end
         send_idle = sidle[ph];
         recv_stall = rstall[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) send(random_item());
      end

      drain();
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
